// ===== rtl/ptp_pkg.sv =====
// Shared constants for the point-triangle proximity test.
package ptp_pkg;

    // Stage count of every wide multiplier
    localparam int MUL_LAT = 4;

    // Edge margin 2^-20 as a shift
    localparam int EDGE_SHIFT = 20;

    // Sum of three 16-bit margins and its square
    localparam int RAD_W = 18;
    localparam int R2_W  = 2 * RAD_W + 1;

    // Configuration register indexes
    localparam logic [1:0] CFG_ALARM    = 2'd0;
    localparam logic [1:0] CFG_POINT    = 2'd1;
    localparam logic [1:0] CFG_TRIANGLE = 2'd2;

    localparam logic [15:0] ALARM_RESET = 16'd256;

    // Outcome codes
    localparam logic [1:0] OUT_HIT  = 2'd0;
    localparam logic [1:0] OUT_MISS = 2'd1;
    localparam logic [1:0] OUT_FAR  = 2'd2;

    localparam int OUT_TW = 8;

endpackage

// ===== rtl/ptp_mul.sv =====
// Pipelined signed multiplier, one operand chunk added per stage.
module ptp_mul #(
    parameter int AW  = 36,
    parameter int BW  = 36,
    parameter int LAT = 4
) (
    input  logic                  clk,
    input  logic                  en,
    input  logic signed [AW-1:0]  a,
    input  logic signed [BW-1:0]  b,
    output logic signed [AW+BW-1:0] p
);
    localparam int CH = (BW + LAT - 1) / LAT;
    localparam int BP = CH * LAT;
    localparam int PW = AW + BP;

    logic signed [AW-1:0] a_reg [LAT-1];
    logic [BP-1:0]        b_reg [LAT-1];
    logic signed [PW-1:0] acc_reg [LAT];
    logic [BP-1:0]        bx;

    // Sign-extend b to whole chunks
    assign bx = BP'(b);

    genvar k;
    for (k = 0; k < LAT; k++)
    begin : g_stage
        logic signed [AW-1:0]   aop;
        logic [BP-1:0]          bop;
        logic signed [CH:0]     chk;
        logic signed [AW+CH:0]  part;

        if (k == 0)
        begin : g_first
            assign aop = a;
            assign bop = bx;
        end
        else
        begin : g_rest
            assign aop = a_reg[k-1];
            assign bop = b_reg[k-1];
        end

        // Top chunk carries the sign, lower chunks are unsigned
        if (k == LAT - 1)
        begin : g_top
            assign chk = $signed({bop[BP-1], bop[k*CH +: CH]});
        end
        else
        begin : g_low
            assign chk = $signed({1'b0, bop[k*CH +: CH]});
        end

        assign part = aop * chk;

        if (k < LAT - 1)
        begin : g_fwd
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    a_reg[k] <= aop;
                    b_reg[k] <= bop;
                end
            end
        end

        // Accumulate the shifted partial product
        if (k == 0)
        begin : g_acc0
            always_ff @(posedge clk)
            begin
                if (en)
                    acc_reg[0] <= PW'(part);
            end
        end
        else
        begin : g_accn
            always_ff @(posedge clk)
            begin
                if (en)
                    acc_reg[k] <= acc_reg[k-1] + (PW'(part) <<< (k * CH));
            end
        end
    end

    assign p = acc_reg[LAT-1][AW+BW-1:0];

endmodule

// ===== rtl/point_triangle_proximity_test.sv =====
// Top level of the point-triangle proximity test pipeline.
//
// Usage:
//   Input stream (s_*): one transfer carries a triangle A, B, C and a probe
//   point P, twelve signed Q8.8 coordinates of COORD_WIDTH bits each.
//   Output stream (m_*): one transfer per input transfer, in order, with a
//   hit flag and an outcome code (hit, outside/degenerate, too far).
//   Configuration: cfg_we writes cfg_wdata into register cfg_addr
//   (0 alarm distance, 1 point proximity, 2 triangle proximity); other
//   indexes are ignored. Write only while the pipeline is empty.
// Timing:
//   From input transfer to output valid the data passes three stages of
//   dot products, two chained multipliers of MUL_LAT stages each, plus
//   determinant, distance-term and final compare stages.
//   One transfer per cycle is accepted as long as the output is taken.
// Reset and stall:
//   Reset empties the pipeline and loads the register defaults (alarm 1.0).
//   When m_tready is low with a result waiting, the whole pipeline holds and
//   s_tready drops; nothing is lost or repeated.
module point_triangle_proximity_test #(
    parameter int COORD_WIDTH = 16
) (
    input  logic clk,
    input  logic rst_n,
    input  logic s_tvalid,
    output logic s_tready,
    // vert_a_x, vert_a_y, vert_a_z, vert_b_x, vert_b_y, vert_b_z,
    // vert_c_x, vert_c_y, vert_c_z, probe_x, probe_y, probe_z
    input  logic [((12*COORD_WIDTH+7)/8)*8-1:0] s_tdata,
    output logic m_tvalid,
    input  logic m_tready,
    // hit (bit 0), outcome (bits 2:1)
    output logic [ptp_pkg::OUT_TW-1:0] m_tdata,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_addr,
    input  logic [15:0] cfg_wdata
);
    import ptp_pkg::*;

    localparam int W  = COORD_WIDTH;
    localparam int DW = W + 1;
    localparam int PW = 2 * DW;
    localparam int SW = PW + 2;
    localparam int MW = 2 * SW;
    localparam int NW = MW + 1;
    localparam int XW = NW + EDGE_SHIFT + 1;
    localparam int QW = NW + SW;
    localparam int LW = ((QW > NW + R2_W) ? QW : NW + R2_W) + 2;
    localparam int NV = 3 + MUL_LAT + 1 + MUL_LAT + 2;

    // Configuration registers
    logic [15:0]          alarm_reg, pprox_reg, tprox_reg;
    logic [RAD_W-1:0]     radius;
    logic [2*RAD_W-1:0]   radius_sq;
    logic signed [R2_W-1:0] r2_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            alarm_reg <= ALARM_RESET;
            pprox_reg <= '0;
            tprox_reg <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                CFG_ALARM:    alarm_reg <= cfg_wdata;
                CFG_POINT:    pprox_reg <= cfg_wdata;
                CFG_TRIANGLE: tprox_reg <= cfg_wdata;
                default:      ;
            endcase
        end
    end

    assign radius    = RAD_W'(alarm_reg) + RAD_W'(pprox_reg) + RAD_W'(tprox_reg);
    assign radius_sq = radius * radius;

    // Square of the radius, refreshed every cycle
    always_ff @(posedge clk)
    begin
        r2_reg <= $signed({1'b0, radius_sq});
    end

    // Pipeline advance and valid bits
    logic          en;
    logic [NV-1:0] vld_reg;

    assign en       = !vld_reg[NV-1] || m_tready;
    assign s_tready = en;
    assign m_tvalid = vld_reg[NV-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= {vld_reg[NV-2:0], s_tvalid};
    end

    // Stage 1: edge and probe vectors relative to A
    logic signed [DW-1:0] ab_reg [3];
    logic signed [DW-1:0] ac_reg [3];
    logic signed [DW-1:0] ap_reg [3];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                ab_reg[i] <= DW'($signed(s_tdata[(3+i)*W +: W]))
                           - DW'($signed(s_tdata[i*W +: W]));
                ac_reg[i] <= DW'($signed(s_tdata[(6+i)*W +: W]))
                           - DW'($signed(s_tdata[i*W +: W]));
                ap_reg[i] <= DW'($signed(s_tdata[(9+i)*W +: W]))
                           - DW'($signed(s_tdata[i*W +: W]));
            end
        end
    end

    // Stage 2: component products
    logic signed [PW-1:0] pbb_reg [3], pcc_reg [3], pbc_reg [3];
    logic signed [PW-1:0] ppb_reg [3], ppc_reg [3], ppp_reg [3];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 3; i++)
            begin
                pbb_reg[i] <= ab_reg[i] * ab_reg[i];
                pcc_reg[i] <= ac_reg[i] * ac_reg[i];
                pbc_reg[i] <= ab_reg[i] * ac_reg[i];
                ppb_reg[i] <= ap_reg[i] * ab_reg[i];
                ppc_reg[i] <= ap_reg[i] * ac_reg[i];
                ppp_reg[i] <= ap_reg[i] * ap_reg[i];
            end
        end
    end

    // Stage 3: dot products
    logic signed [SW-1:0] a00_reg, a11_reg, a01_reg, b0_reg, b1_reg, app_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a00_reg <= SW'(pbb_reg[0]) + SW'(pbb_reg[1]) + SW'(pbb_reg[2]);
            a11_reg <= SW'(pcc_reg[0]) + SW'(pcc_reg[1]) + SW'(pcc_reg[2]);
            a01_reg <= SW'(pbc_reg[0]) + SW'(pbc_reg[1]) + SW'(pbc_reg[2]);
            b0_reg  <= SW'(ppb_reg[0]) + SW'(ppb_reg[1]) + SW'(ppb_reg[2]);
            b1_reg  <= SW'(ppc_reg[0]) + SW'(ppc_reg[1]) + SW'(ppc_reg[2]);
            app_reg <= SW'(ppp_reg[0]) + SW'(ppp_reg[1]) + SW'(ppp_reg[2]);
        end
    end

    // Round one of the Gram system products
    logic signed [MW-1:0] m00_11, m01_01, mb0_11, mb1_01, mb1_00, mb0_01;

    ptp_mul #(.AW(SW), .BW(SW), .LAT(MUL_LAT)) u_m0
        (.clk(clk), .en(en), .a(a00_reg), .b(a11_reg), .p(m00_11));
    ptp_mul #(.AW(SW), .BW(SW), .LAT(MUL_LAT)) u_m1
        (.clk(clk), .en(en), .a(a01_reg), .b(a01_reg), .p(m01_01));
    ptp_mul #(.AW(SW), .BW(SW), .LAT(MUL_LAT)) u_m2
        (.clk(clk), .en(en), .a(b0_reg), .b(a11_reg), .p(mb0_11));
    ptp_mul #(.AW(SW), .BW(SW), .LAT(MUL_LAT)) u_m3
        (.clk(clk), .en(en), .a(b1_reg), .b(a01_reg), .p(mb1_01));
    ptp_mul #(.AW(SW), .BW(SW), .LAT(MUL_LAT)) u_m4
        (.clk(clk), .en(en), .a(b1_reg), .b(a00_reg), .p(mb1_00));
    ptp_mul #(.AW(SW), .BW(SW), .LAT(MUL_LAT)) u_m5
        (.clk(clk), .en(en), .a(b0_reg), .b(a01_reg), .p(mb0_01));

    // Carry b0, b1 and |AP|^2 alongside round one
    logic signed [SW-1:0] b0_dly [MUL_LAT+1];
    logic signed [SW-1:0] b1_dly [MUL_LAT+1];
    logic signed [SW-1:0] app_dly [MUL_LAT+1];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            b0_dly[0]  <= b0_reg;
            b1_dly[0]  <= b1_reg;
            app_dly[0] <= app_reg;
            for (int i = 1; i <= MUL_LAT; i++)
            begin
                b0_dly[i]  <= b0_dly[i-1];
                b1_dly[i]  <= b1_dly[i-1];
                app_dly[i] <= app_dly[i-1];
            end
        end
    end

    // Determinant and barycentric numerators
    logic signed [NW-1:0] det_reg, na_reg, nb_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            det_reg <= NW'(m00_11) - NW'(m01_01);
            na_reg  <= NW'(mb0_11) - NW'(mb1_01);
            nb_reg  <= NW'(mb1_00) - NW'(mb0_01);
        end
    end

    // Round two: distance products
    logic signed [QW-1:0]        q_app_det, q_b0_na, q_b1_nb;
    logic signed [NW+R2_W-1:0]   q_r2_det;

    ptp_mul #(.AW(NW), .BW(SW), .LAT(MUL_LAT)) u_q0
        (.clk(clk), .en(en), .a(det_reg), .b(app_dly[MUL_LAT]), .p(q_app_det));
    ptp_mul #(.AW(NW), .BW(SW), .LAT(MUL_LAT)) u_q1
        (.clk(clk), .en(en), .a(na_reg), .b(b0_dly[MUL_LAT]), .p(q_b0_na));
    ptp_mul #(.AW(NW), .BW(SW), .LAT(MUL_LAT)) u_q2
        (.clk(clk), .en(en), .a(nb_reg), .b(b1_dly[MUL_LAT]), .p(q_b1_nb));
    ptp_mul #(.AW(NW), .BW(R2_W), .LAT(MUL_LAT)) u_q3
        (.clk(clk), .en(en), .a(det_reg), .b(r2_reg), .p(q_r2_det));

    // Edge tests, first half: zero determinant, two lower margins and operands of the third
    logic                 dz_reg, low_fail_reg;
    logic signed [XW-1:0] nsum_sh_reg, detm_reg;
    logic signed [XW-1:0] det_x, na_sh, nb_sh, det_sh;

    assign det_x  = XW'(det_reg);
    assign na_sh  = XW'(na_reg) <<< EDGE_SHIFT;
    assign nb_sh  = XW'(nb_reg) <<< EDGE_SHIFT;
    assign det_sh = det_x <<< EDGE_SHIFT;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dz_reg       <= (det_reg == '0);
            low_fail_reg <= (na_sh < det_x) || (nb_sh < det_x);
            nsum_sh_reg  <= (XW'(na_reg) + XW'(nb_reg)) <<< EDGE_SHIFT;
            detm_reg     <= det_sh - det_x;
        end
    end

    // Edge tests, second half: combine into one miss flag
    logic miss_dly [MUL_LAT-1];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            miss_dly[0] <= dz_reg || low_fail_reg || (detm_reg < nsum_sh_reg);
            for (int i = 1; i < MUL_LAT - 1; i++)
                miss_dly[i] <= miss_dly[i-1];
        end
    end

    // Distance terms: |AP|^2*det - R^2*det against b0*na + b1*nb
    logic signed [LW-1:0] u_reg, s_reg;
    logic                 miss_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            u_reg    <= LW'(q_app_det) - LW'(q_r2_det);
            s_reg    <= LW'(q_b0_na) + LW'(q_b1_nb);
            miss_reg <= miss_dly[MUL_LAT-2];
        end
    end

    // Output register
    logic [1:0] outcome_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            priority if (miss_reg)
                outcome_reg <= OUT_MISS;
            else if (u_reg < s_reg)
                outcome_reg <= OUT_HIT;
            else
                outcome_reg <= OUT_FAR;
        end
    end

    assign m_tdata = {{(OUT_TW-3){1'b0}}, outcome_reg, (outcome_reg == OUT_HIT)};

endmodule

// ===== rtl/ptp_check.sv =====
// Port-level checks for the point-triangle proximity test, bound to the top.
module ptp_check (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         s_tready,
    input logic                         m_tvalid,
    input logic                         m_tready,
    input logic [ptp_pkg::OUT_TW-1:0]   m_tdata
);
    import ptp_pkg::*;

    // Hit flag agrees with the outcome code
    a_hit_code: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[0] == (m_tdata[2:1] == OUT_HIT)))
        else $error("hit flag disagrees with outcome");

    // Outcome is one of the three codes, padding is zero
    a_code_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> ((m_tdata[2:1] == OUT_HIT || m_tdata[2:1] == OUT_MISS ||
                       m_tdata[2:1] == OUT_FAR) && m_tdata[OUT_TW-1:3] == '0))
        else $error("bad outcome code");

    // Input side stalls exactly when a result is held
    a_ready_link: assert property (@(posedge clk) disable iff (!rst_n)
        s_tready == (!m_tvalid || m_tready))
        else $error("input ready does not follow output stall");

    // Held result stays put
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("stalled result changed");

endmodule

bind point_triangle_proximity_test ptp_check u_ptp_check (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

// ===== dv/testbench.sv =====
// Self-checking testbench for the point-triangle proximity test.
`timescale 1ns / 100ps

module testbench;
    import ptp_pkg::*;

    localparam int CW = 16;
    localparam int DW = ((12 * CW + 7) / 8) * 8;
    localparam int LATENCY = 14;
    localparam longint LIMIT = 400000;

    typedef struct packed {
        logic       hit;
        logic [1:0] outcome;
    } verdict_t;

    logic clk;
    logic rst_n;
    logic s_tvalid;
    logic s_tready;
    logic [DW-1:0] s_tdata;
    logic m_tvalid;
    logic m_tready;
    logic [OUT_TW-1:0] m_tdata;
    logic cfg_we;
    logic [1:0] cfg_addr;
    logic [15:0] cfg_wdata;

    // Local copy of the radius registers
    logic [15:0] alarm_reg;
    logic [15:0] point_reg;
    logic [15:0] tri_reg;

    logic [DW-1:0] pending_items[$];
    verdict_t expected_verdicts[$];
    int mismatches;
    longint cycles;
    bit quiet;
    int src_gap;
    int snk_gap;

    point_triangle_proximity_test #(.COORD_WIDTH(CW)) dut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Exact integer classification of one triangle/probe pair
    function automatic verdict_t classify_pair(logic [DW-1:0] d);
        logic signed [16:0] ab[3];
        logic signed [16:0] ac[3];
        logic signed [16:0] ap[3];
        logic signed [255:0] a00, a11, a01, b0, b1, pp, det, na, nb, rad, lhs, rhs;
        logic signed [15:0] va;
        verdict_t v;
        for (int i = 0; i < 3; i++)
        begin
            va = d[i*16 +: 16];
            ab[i] = $signed(d[(3+i)*16 +: 16]) - va;
            ac[i] = $signed(d[(6+i)*16 +: 16]) - va;
            ap[i] = $signed(d[(9+i)*16 +: 16]) - va;
        end
        a00 = 0; a11 = 0; a01 = 0; b0 = 0; b1 = 0; pp = 0;
        for (int i = 0; i < 3; i++)
        begin
            a00 += 256'(ab[i]) * 256'(ab[i]);
            a11 += 256'(ac[i]) * 256'(ac[i]);
            a01 += 256'(ab[i]) * 256'(ac[i]);
            b0 += 256'(ap[i]) * 256'(ab[i]);
            b1 += 256'(ap[i]) * 256'(ac[i]);
            pp += 256'(ap[i]) * 256'(ap[i]);
        end
        det = a00 * a11 - a01 * a01;
        v.hit = 1'b0;
        v.outcome = OUT_MISS;
        if (det == 0)
            return v;
        na = b0 * a11 - b1 * a01;
        nb = b1 * a00 - b0 * a01;
        if ((na <<< EDGE_SHIFT) < det || (nb <<< EDGE_SHIFT) < det)
            return v;
        if (det * ((256'sd1 <<< EDGE_SHIFT) - 1) < ((na + nb) <<< EDGE_SHIFT))
            return v;
        rad = $signed({238'd0, 18'(alarm_reg) + 18'(point_reg) + 18'(tri_reg)});
        lhs = pp * det - (b0 * na + b1 * nb);
        rhs = rad * rad * det;
        if (lhs < rhs)
        begin
            v.hit = 1'b1;
            v.outcome = OUT_HIT;
        end
        else
            v.outcome = OUT_FAR;
        return v;
    endfunction

    function automatic logic [DW-1:0] pack_item(logic [15:0] c[12]);
        logic [DW-1:0] d;
        d = '0;
        for (int i = 0; i < 12; i++)
            d[i*16 +: 16] = c[i];
        return d;
    endfunction

    // Build a random pair; shapes vary from tiny to full-range coordinates
    function automatic logic [DW-1:0] random_pair();
        logic [15:0] c[12];
        int span;
        int mode;
        int u, w;
        mode = $urandom_range(0, 9);
        span = (mode < 3) ? 32767 : (mode < 7 ? 2047 : 255);
        for (int i = 0; i < 9; i++)
            c[i] = 16'($signed($urandom_range(0, 2 * span)) - span);
        if (mode >= 3 && mode < 9)
        begin
            // probe near the interior: centroid-like mix plus a small offset
            u = $urandom_range(1, 6);
            w = $urandom_range(1, 7 - u);
            for (int i = 0; i < 3; i++)
                c[9+i] = 16'(($signed(c[i]) * (8 - u - w) + $signed(c[3+i]) * u
                              + $signed(c[6+i]) * w) / 8
                             + $signed($urandom_range(0, 1024)) - 512);
        end
        else
            for (int i = 9; i < 12; i++)
                c[i] = 16'($urandom);
        if ($urandom_range(0, 30) == 0)
            for (int i = 0; i < 3; i++)
                c[6+i] = c[3+i];
        return pack_item(c);
    endfunction

    task automatic queue_pair(logic [15:0] c[12]);
        pending_items.push_back(pack_item(c));
    endtask

    task automatic drain();
        while (pending_items.size() != 0 || s_tvalid || expected_verdicts.size() != 0)
            @(posedge clk);
        repeat (LATENCY + 4) @(posedge clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [15:0] val);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_addr <= idx;
        cfg_wdata <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_ALARM: alarm_reg = val;
            CFG_POINT: point_reg = val;
            CFG_TRIANGLE: tri_reg = val;
            default: ;
        endcase
    endtask

    task automatic random_phase(int n);
        for (int i = 0; i < n; i++)
            pending_items.push_back(random_pair());
        drain();
    endtask

    // Drive input transfers from the pending queue
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata <= '0;
            src_gap <= 0;
        end
        else
        begin
            if (s_tvalid && s_tready)
                expected_verdicts.push_back(classify_pair(s_tdata));
            if (!s_tvalid || s_tready)
            begin
                if (src_gap > 0)
                begin
                    src_gap <= src_gap - 1;
                    s_tvalid <= 1'b0;
                end
                else if (pending_items.size() != 0)
                begin
                    s_tvalid <= 1'b1;
                    s_tdata <= pending_items.pop_front();
                    if (!quiet && $urandom_range(0, 19) == 0)
                        src_gap <= $urandom_range(1, 14);
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // Check output transfers and toggle the ready side
    always @(posedge clk or negedge rst_n)
    begin
        verdict_t got, want;
        if (!rst_n)
        begin
            m_tready <= 1'b0;
            snk_gap <= 0;
        end
        else
        begin
            cycles <= cycles + 1;
            if (m_tvalid && m_tready)
            begin
                got.hit = m_tdata[0];
                got.outcome = m_tdata[2:1];
                if (expected_verdicts.size() == 0)
                begin
                    mismatches <= mismatches + 1;
                    if (mismatches < 10)
                        $display("unexpected output transfer %h", m_tdata);
                end
                else
                begin
                    want = expected_verdicts.pop_front();
                    if (got !== want)
                    begin
                        mismatches <= mismatches + 1;
                        if (mismatches < 10)
                            $display("mismatch: hit exp %0d got %0d, outcome exp %0d got %0d",
                                     want.hit, got.hit, want.outcome, got.outcome);
                    end
                end
            end
            if (snk_gap > 0)
            begin
                snk_gap <= snk_gap - 1;
                m_tready <= 1'b0;
            end
            else if (!quiet && $urandom_range(0, 15) == 0)
            begin
                snk_gap <= $urandom_range(0, 13);
                m_tready <= 1'b0;
            end
            else
                m_tready <= 1'b1;
        end
    end

    // Timeout
    always @(posedge clk)
    begin
        if (cycles > LIMIT)
        begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial
    begin
        logic [15:0] c[12];
        mismatches = 0;
        cycles = 0;
        quiet = 1'b0;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_addr = CFG_ALARM;
        cfg_wdata = '0;
        alarm_reg = ALARM_RESET;
        point_reg = '0;
        tri_reg = '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: right triangle in z=0 plane with probes at chosen spots
        c = '{0, 0, 0, 1024, 0, 0, 0, 1024, 0, 128, 128, 100};
        queue_pair(c);
        c[11] = 300;
        queue_pair(c);
        c[11] = 0;
        queue_pair(c);
        c[9] = 0; c[10] = 0;           // probe on a vertex, on edges
        queue_pair(c);
        c[9] = 512; c[10] = 512;       // on the hypotenuse
        queue_pair(c);
        c[9] = -10; c[10] = 100;       // outside
        queue_pair(c);
        c[9] = 511; c[10] = 512;       // just inside the hypotenuse
        queue_pair(c);
        // degenerate: collinear and coincident vertices
        c = '{0, 0, 0, 100, 100, 100, 200, 200, 200, 5, 5, 5};
        queue_pair(c);
        c = '{7, 7, 7, 7, 7, 7, 7, 7, 7, 7, 7, 7};
        queue_pair(c);
        // extremes of every coordinate
        c = '{16'h8000, 16'h8000, 16'h8000, 16'h7fff, 16'h8000, 16'h8000,
              16'h8000, 16'h7fff, 16'h8000, 16'h8000, 16'h8000, 16'h7fff};
        queue_pair(c);
        c = '{16'h7fff, 16'h7fff, 16'h7fff, 16'h8000, 16'h7fff, 16'h7fff,
              16'h7fff, 16'h8000, 16'h7fff, 16'hc000, 16'hc000, 16'h7fff};
        queue_pair(c);
        c = '{16'hffff, 0, 0, 0, 16'hffff, 0, 0, 0, 16'hffff, 0, 0, 0};
        queue_pair(c);
        drain();

        // Sender pauses until every result is back, then random traffic
        random_phase(250);
        write_reg(CFG_ALARM, 16'hffff);
        write_reg(CFG_POINT, 16'hffff);
        write_reg(CFG_TRIANGLE, 16'hffff);
        random_phase(200);
        write_reg(CFG_ALARM, 16'd0);
        write_reg(CFG_POINT, 16'd0);
        write_reg(CFG_TRIANGLE, 16'd0);
        c = '{0, 0, 0, 1024, 0, 0, 0, 1024, 0, 128, 128, 0};
        queue_pair(c);
        random_phase(150);
        write_reg(CFG_ALARM, 16'($urandom_range(0, 2048)));
        write_reg(CFG_POINT, 16'($urandom_range(0, 1024)));
        write_reg(CFG_TRIANGLE, 16'($urandom_range(0, 1024)));
        write_reg(2'd3, 16'h1234);
        random_phase(250);
        quiet = 1'b1;
        random_phase(190);

        if (mismatches == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
